FILE: hdl/epq_pkg.sv
// Shared types, constants and formula decode for the e-paper pixel quantizer.
`timescale 1ns / 1ps

package epq_pkg;

  // Screen geometry and dither table shape.
  localparam int unsigned PANEL_COLS    = 1404;
  localparam int unsigned PANEL_ROWS    = 1872;
  localparam int unsigned DITHER_BITS   = 7;
  localparam int unsigned DITHER_SIDE   = 1 << DITHER_BITS;
  localparam int unsigned DITHER_ADDR_W = 2 * DITHER_BITS;
  localparam int unsigned DITHER_DEPTH  = DITHER_SIDE * DITHER_SIDE;

  // Field widths.
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned OFFSET_W = 22;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned SUM_W    = 7;
  localparam int unsigned PITCH_W  = COORD_W + 1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORMULA_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM     = 3'd5;

  // Request kinds carried on the input tuser.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Pixel formula selector codes.
  localparam logic [3:0] MODE_AUTO       = 4'd5;
  localparam logic [3:0] MODE_DITHER_A   = 4'd6;
  localparam logic [3:0] MODE_BACK_GATED = 4'd7;
  localparam logic [3:0] MODE_DITHER_B   = 4'd8;
  localparam logic [3:0] MODE_FINE       = 4'd9;
  localparam logic [3:0] MODE_FIXED      = 4'd13;
  localparam logic [3:0] MODE_NONE       = 4'd0;

  // Level constants.
  localparam logic [LEVEL_W-1:0] LEVEL_BACK_IDLE = 8'h20;
  localparam logic [LEVEL_W-1:0] LEVEL_FIXED     = 8'h1e;
  localparam int unsigned        LEVEL_DIVISOR   = 125;
  localparam int unsigned        LEVEL_STEP      = 30;
  localparam int unsigned        FINE_GAIN       = 15;
  // Reciprocal of the divisor: floor(v * RECIP >> RECIP_SHIFT) == v / 125 for v < 6026.
  localparam int unsigned        RECIP_SHIFT     = 19;
  localparam int unsigned        RECIP           = ((1 << RECIP_SHIFT) + LEVEL_DIVISOR - 1)
                                                   / LEVEL_DIVISOR;
  localparam int unsigned        RECIP_W         = 13;
  localparam int unsigned        FINE_Q_W        = 5;

  // Datapath class of the chosen formula.
  typedef enum logic [2:0] {
    F_DITHER,
    F_BACK_GATED,
    F_FINE,
    F_FIXED,
    F_SHIFT
  } formula_t;

  // One result item.
  typedef struct packed {
    logic                outside_rect;
    logic [OFFSET_W-1:0] dest_offset;
    logic [LEVEL_W-1:0]  drive_byte;
  } result_t;

  // Automatic choice: waveform modes 1 to 7 map onto a fixed formula list.
  function automatic logic [3:0] auto_mode(input logic [7:0] wave);
    logic [3:0] m;
    case (wave)
      8'd1:    m = MODE_DITHER_A;
      8'd2:    m = MODE_FINE;
      8'd3:    m = MODE_FINE;
      8'd4:    m = MODE_FINE;
      8'd5:    m = MODE_FINE;
      8'd6:    m = MODE_DITHER_A;
      8'd7:    m = MODE_DITHER_B;
      default: m = MODE_NONE;
    endcase
    return m;
  endfunction

  // Resolve the selector and waveform mode to a datapath class.
  function automatic formula_t pick_formula(input logic [3:0] mode, input logic [7:0] wave);
    logic [3:0] m;
    formula_t   f;
    m = (mode == MODE_AUTO) ? auto_mode(wave) : mode;
    case (m)
      MODE_DITHER_A:   f = F_DITHER;
      MODE_DITHER_B:   f = F_DITHER;
      MODE_BACK_GATED: f = F_BACK_GATED;
      MODE_FINE:       f = F_FINE;
      MODE_FIXED:      f = F_FIXED;
      default:         f = F_SHIFT;
    endcase
    return f;
  endfunction

endpackage

FILE: hdl/epq_dither_mem.sv
// Dither table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module epq_dither_mem (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [epq_pkg::DITHER_ADDR_W-1:0] wr_addr,
  input  logic [7:0]                       wr_data,
  input  logic                             rd_en,
  input  logic [epq_pkg::DITHER_ADDR_W-1:0] rd_addr,
  output logic [7:0]                       rd_data
);

  logic [7:0] mem [epq_pkg::DITHER_DEPTH];

  // Table writes from load requests.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is held while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/epq_level.sv
// Drive level datapath: combines the color sum with the dither cell.
`timescale 1ns / 1ps

module epq_level (
  input  logic                          clk,
  input  logic                          en,
  input  logic [epq_pkg::SUM_W-1:0]     color_sum,
  input  logic                          back_set,
  input  epq_pkg::formula_t             formula,
  input  logic [7:0]                    dither,
  output logic [epq_pkg::LEVEL_W-1:0]   drive_byte
);

  localparam logic [8:0] DIV_1 = 9'(epq_pkg::LEVEL_DIVISOR);
  localparam logic [8:0] DIV_2 = 9'(2 * epq_pkg::LEVEL_DIVISOR);
  localparam logic [8:0] DIV_3 = 9'(3 * epq_pkg::LEVEL_DIVISOR);
  localparam int unsigned FINE_W = 12;
  localparam int unsigned PROD_W = FINE_W + epq_pkg::RECIP_W;

  logic [8:0]                   coarse_sum;
  logic [1:0]                   coarse_q;
  logic [epq_pkg::LEVEL_W-1:0]  coarse_level;
  logic [FINE_W-1:0]            fine_sum;
  logic [PROD_W-1:0]            fine_prod;
  logic [epq_pkg::LEVEL_W-1:0]  level_next;
  logic [epq_pkg::LEVEL_W-1:0]  level;
  logic                         is_fine;
  logic [epq_pkg::FINE_Q_W-1:0] fine_q;

  // Coarse formula: (sum + dither) / 125 stays below four, so three compares do it.
  always_comb begin
    coarse_sum = {2'b00, color_sum} + {1'b0, dither};
    if (coarse_sum >= DIV_3) begin
      coarse_q = 2'd3;
    end else if (coarse_sum >= DIV_2) begin
      coarse_q = 2'd2;
    end else if (coarse_sum >= DIV_1) begin
      coarse_q = 2'd1;
    end else begin
      coarse_q = 2'd0;
    end
    coarse_level = 8'(coarse_q) * 8'(epq_pkg::LEVEL_STEP);
  end

  // Fine formula: sum * 15 + dither, divided through the reciprocal product.
  always_comb begin
    fine_sum  = ({5'b0, color_sum} << 4) - {5'b0, color_sum} + {4'b0, dither};
    fine_prod = {{epq_pkg::RECIP_W{1'b0}}, fine_sum} *
                {{FINE_W{1'b0}}, epq_pkg::RECIP_W'(epq_pkg::RECIP)};
  end

  // Levels that need no division result.
  always_comb begin
    case (formula)
      epq_pkg::F_DITHER:     level_next = coarse_level;
      epq_pkg::F_BACK_GATED: level_next = back_set ? coarse_level : epq_pkg::LEVEL_BACK_IDLE;
      epq_pkg::F_FIXED:      level_next = epq_pkg::LEVEL_FIXED;
      epq_pkg::F_SHIFT:      level_next = {3'b000, color_sum[epq_pkg::SUM_W-1:3], 1'b0};
      default:               level_next = '0;
    endcase
  end

  // Stage register after the multiplier.
  always_ff @(posedge clk) begin
    if (en) begin
      level   <= level_next;
      is_fine <= (formula == epq_pkg::F_FINE);
      fine_q  <= fine_prod[epq_pkg::RECIP_SHIFT +: epq_pkg::FINE_Q_W];
    end
  end

  // The fine quotient is doubled.
  assign drive_byte = is_fine ? {2'b00, fine_q, 1'b0} : level;

endmodule

FILE: hdl/epq_out_skid.sv
// Output register with a skid stage that decouples the pipeline from tready.
`timescale 1ns / 1ps

module epq_out_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  epq_pkg::result_t in_item,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output epq_pkg::result_t out_item
);

  logic             skid_valid;
  epq_pkg::result_t skid_item;

  assign in_ready = !skid_valid;

  // Output and skid occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves with the occupancy bits.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_item <= skid_valid ? skid_item : in_item;
    end else if (!skid_valid) begin
      skid_item <= in_item;
    end
  end

endmodule

FILE: hdl/epd_pixel_gray_quantizer_unit.sv
// Top level of the e-paper pixel quantizer: input stage, offset path and output.
`timescale 1ns / 1ps

// Takes one request per clock, load or render, whenever s_tready is high; a
// render result passes the table read and stage one registers, the level and
// offset stage and the output register before it shows on m_tvalid, and load
// requests give no result. Throughput is one request per clock while s_tready
// is high: the 128x128 dither table has a write port for loads and a
// registered read port for the render cell, each used at most once per
// request. The table holds no reset value and needs no clearing pass: render
// requests must only address cells that were loaded before. s_tready falls
// only while the output is held by m_tready and a result waits in the skid
// stage. Configuration writes are always taken (cfg_ready is tied high) and
// must be made while idle.
module epd_pixel_gray_quantizer_unit (
  input  logic                               clk,
  input  logic                               rst,
  // cfg_data: rect coordinates in [10:0], formula mode in [3:0], waveform mode in [7:0]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [epq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [epq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata: cell_row[6:0], cell_col[13:7], cell_value[21:14], rgb_pixel[37:22],
  //          back_set[38], screen_row[49:39], screen_col[60:50], zero[63:61]
  input  logic [63:0]                        s_tdata,
  // s_tuser: opcode[0]
  input  logic [0:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata: drive_byte[7:0], dest_offset[29:8], outside_rect[30], zero[31]
  output logic [31:0]                        m_tdata
);

  localparam int unsigned CW = epq_pkg::COORD_W;
  localparam int unsigned DB = epq_pkg::DITHER_BITS;
  localparam logic [CW-1:0] ROW_LAST = CW'(epq_pkg::PANEL_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(epq_pkg::PANEL_COLS - 1);
  localparam int unsigned PROD_W = CW + epq_pkg::PITCH_W;

  // Configuration registers.
  logic [CW-1:0] rect_top;
  logic [CW-1:0] rect_left;
  logic [CW-1:0] rect_bottom;
  logic [CW-1:0] rect_right;
  logic [3:0]    pixel_formula_mode;
  logic [7:0]    waveform_mode;

  // Request fields.
  logic          in_op;
  logic [DB-1:0] cell_row;
  logic [DB-1:0] cell_col;
  logic [7:0]    cell_value;
  logic [15:0]   rgb_pixel;
  logic          back_set;
  logic [CW-1:0] screen_row;
  logic [CW-1:0] screen_col;

  // Input stage decode.
  logic                           en;
  logic                           accept;
  logic [epq_pkg::SUM_W-1:0]      sum0;
  logic [CW-1:0]                  rot_row;
  logic [CW-1:0]                  rot_col;
  logic                           outside0;
  logic [CW-1:0]                  rect_height;
  logic [epq_pkg::PITCH_W-1:0]    pitch0;

  // Stage one.
  logic                           valid1;
  logic [epq_pkg::SUM_W-1:0]      sum1;
  logic                           back1;
  epq_pkg::formula_t              formula1;
  logic                           outside1;
  logic [CW-1:0]                  dx1;
  logic [CW-1:0]                  dy1;
  logic [epq_pkg::PITCH_W-1:0]    pitch1;
  logic [7:0]                     dither1;

  // Stage two.
  logic                           valid2;
  logic                           outside2;
  logic [CW-1:0]                  dy2;
  logic [PROD_W-1:0]              prod2;
  logic [PROD_W-1:0]              offset_sum;
  epq_pkg::result_t               result2;
  logic [epq_pkg::LEVEL_W-1:0]    level2;
  epq_pkg::result_t               out_item;

  // Unpack the request.
  assign in_op       = s_tuser[0];
  assign cell_row    = s_tdata[6:0];
  assign cell_col    = s_tdata[13:7];
  assign cell_value  = s_tdata[21:14];
  assign rgb_pixel   = s_tdata[37:22];
  assign back_set    = s_tdata[38];
  assign screen_row  = s_tdata[49:39];
  assign screen_col  = s_tdata[60:50];

  // Configuration writes; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_top           <= '0;
      rect_left          <= '0;
      rect_bottom        <= ROW_LAST;
      rect_right         <= COL_LAST;
      pixel_formula_mode <= epq_pkg::MODE_AUTO;
      waveform_mode      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        epq_pkg::REG_RECT_TOP:     rect_top           <= cfg_data;
        epq_pkg::REG_RECT_LEFT:    rect_left          <= cfg_data;
        epq_pkg::REG_RECT_BOTTOM:  rect_bottom        <= cfg_data;
        epq_pkg::REG_RECT_RIGHT:   rect_right         <= cfg_data;
        epq_pkg::REG_FORMULA_MODE: pixel_formula_mode <= cfg_data[3:0];
        epq_pkg::REG_WAVEFORM:     waveform_mode      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the skid stage is occupied.
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  function automatic logic [epq_pkg::SUM_W-1:0] SUM_W_EXT(input logic [4:0] v);
    return epq_pkg::SUM_W'(v);
  endfunction

  // Rotation by 180 degrees; the low bits pick the dither cell even on wrap.
  always_comb begin
    rot_row     = ROW_LAST - screen_row;
    rot_col     = COL_LAST - screen_col;
    sum0        = SUM_W_EXT(rgb_pixel[4:0]) + SUM_W_EXT(rgb_pixel[15:11])
                  + epq_pkg::SUM_W'(rgb_pixel[10:5]);
    outside0    = (screen_row < rect_top) || (screen_row > rect_bottom) ||
                  (screen_col < rect_left) || (screen_col > rect_right);
    rect_height = rect_bottom - rect_top;
    pitch0      = ({1'b0, rect_height} + epq_pkg::PITCH_W'(16)) &
                  ~epq_pkg::PITCH_W'(15);
  end

  // Dither table: loads write, every advancing cycle reads the render cell.
  epq_dither_mem u_mem (
    .clk     (clk),
    .wr_en   (accept && (in_op == epq_pkg::OP_LOAD)),
    .wr_addr ({cell_row, cell_col}),
    .wr_data (cell_value),
    .rd_en   (en),
    .rd_addr ({rot_row[DB-1:0], rot_col[DB-1:0]}),
    .rd_data (dither1)
  );

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (en) begin
      valid1 <= accept && (in_op == epq_pkg::OP_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1     <= sum0;
      back1    <= back_set;
      formula1 <= epq_pkg::pick_formula(pixel_formula_mode, waveform_mode);
      outside1 <= outside0;
      dx1      <= screen_col - rect_left;
      dy1      <= screen_row - rect_top;
      pitch1   <= pitch0;
    end
  end

  // Level datapath spans stage one and stage two.
  epq_level u_level (
    .clk         (clk),
    .en          (en),
    .color_sum   (sum1),
    .back_set    (back1),
    .formula     (formula1),
    .dither      (dither1),
    .drive_byte  (level2)
  );

  // Stage two: column times stride, row added after the register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (en) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outside2 <= outside1;
      dy2      <= dy1;
      prod2    <= {{epq_pkg::PITCH_W{1'b0}}, dx1} * {{CW{1'b0}}, pitch1};
    end
  end

  always_comb begin
    offset_sum           = prod2 + PROD_W'(dy2);
    result2.drive_byte   = level2;
    result2.outside_rect = outside2;
    result2.dest_offset  = outside2 ? '0 : offset_sum[epq_pkg::OFFSET_W-1:0];
  end

  // Output register and skid stage.
  epq_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid2),
    .in_item   (result2),
    .in_ready  (en),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {1'b0, out_item};

`ifndef SYNTHESIS
  // Backpressure reaches the input only while a result is held at the output.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result at the output");

  // The skid stage drains only after the output was taken.
  a_drain_after_take: assert property (@(posedge clk) disable iff (rst)
    $rose(s_tready) |-> $past(m_tready))
    else $error("skid stage drained without an output transfer");

  // A result outside the rectangle carries a zero offset.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[30]) |-> (m_tdata[29:8] == 22'd0))
    else $error("outside result with nonzero offset");
`endif

endmodule
